@@ hw/rtl/sha1_message_digest_core_assert.svh @@
// ---------------------------------------------------------------------------
// sha1 digest core assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_CORE_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// implication in the same cycle
`define SHA1MD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sha1md check failed");

// implication in the next cycle
`define SHA1MD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sha1md check failed");

`else

`define SHA1MD_ASSERT_NOW(lbl, ante, cons)
`define SHA1MD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/sha1md_pkg.sv @@
// ---------------------------------------------------------------------------
// sha1md_pkg
// widths, initial chain, round constants and sequencer states of the core
// ---------------------------------------------------------------------------
package sha1md_pkg;

	localparam int BYTE_W      = 8;
	localparam int WORD_W      = 32;
	localparam int WIDX_W      = 3;
	localparam int CHAIN_WORDS = 5;
	localparam int SCHED_DEPTH = 16;
	localparam int SCHED_AW    = 4;
	localparam int HIST_DEPTH  = 8;
	localparam int RND_W       = 7;

	localparam logic [RND_W-1:0] LAST_ROUND  = 7'd79;
	localparam logic [RND_W-1:0] MSG_ROUNDS  = 7'd16;
	localparam logic [RND_W-1:0] PH1_ROUND   = 7'd20;
	localparam logic [RND_W-1:0] PH2_ROUND   = 7'd40;
	localparam logic [RND_W-1:0] PH3_ROUND   = 7'd60;
	localparam logic [WIDX_W-1:0] LAST_WIDX  = 3'd4;
	localparam logic [5:0] LAST_FILL         = 6'd63;
	localparam logic [SCHED_AW-1:0] LEN_HI_WORD = 4'd14;
	localparam logic [SCHED_AW-1:0] LEN_LO_WORD = 4'd15;
	localparam logic [BYTE_W-1:0] PAD_BYTE   = 8'h80;

	localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
	localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
	localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
	localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

	localparam logic [WORD_W-1:0] INIT_CHAIN [CHAIN_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREFETCH,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_OUT
	} st_t;

endpackage

@@ hw/rtl/sha1md_in_if.sv @@
// ---------------------------------------------------------------------------
// sha1md_in_if
// message byte channel: valid, ready and one byte transaction
// ---------------------------------------------------------------------------
interface sha1md_in_if import sha1md_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              has_byte;
	logic              end_of_message;

	modport source (output valid, output data_byte, output has_byte,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input has_byte,
		input end_of_message, output ready);

endinterface

@@ hw/rtl/sha1md_out_if.sv @@
// ---------------------------------------------------------------------------
// sha1md_out_if
// digest channel: valid, ready and one digest word per transaction
// ---------------------------------------------------------------------------
interface sha1md_out_if import sha1md_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] digest_word;
	logic [WIDX_W-1:0] word_index;
	logic              last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last_word, output ready);

endinterface

@@ hw/rtl/sha1_message_digest_core.sv @@
// ---------------------------------------------------------------------------
// sha1_message_digest_core
// byte-serial sha-1 engine built around a 16-word schedule memory
// ---------------------------------------------------------------------------
//
// channel  dir  transaction
// -------  ---  ----------------------------------------------------------
// msg      in   data_byte, has_byte, end_of_message (one byte or an end mark)
// digest   out  digest_word, word_index, last_word (five words per message)
//
// the 64th byte of a block starts a compression (one prefetch, 80 rounds,
// one chain fold); msg.ready is low while it runs, so no new byte is
// taken until the compression is done
// an end mark writes the pad words (up to 16, or up to 18 when the length
// spills into an extra block), compresses, then offers five digest words;
// msg.ready is low until the last digest word is taken
// arst_n loads the initial chain and clears the bit count; the schedule
// memory needs no clearing since every word is written before it is read
// ---------------------------------------------------------------------------
`include "sha1_message_digest_core_assert.svh"

module sha1_message_digest_core
	import sha1md_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	sha1md_in_if.sink    msg,
	sha1md_out_if.source digest
);

	// sequencer
	st_t state_q, state_d;

	// round datapath
	logic [RND_W-1:0]  rnd_q;
	logic [WORD_W-1:0] a_q, b_q, c_q, d_q, e_q;
	logic [WORD_W-1:0] chain_q [CHAIN_WORDS];
	logic [WORD_W-1:0] hist_q [HIST_DEPTH];

	// message state
	logic [63:0]         bit_count_q;
	logic [23:0]         acc_q;
	logic                end_q;
	logic                pad_started_q;
	logic                pad_done_q;
	logic                len_ok_q;
	logic [SCHED_AW-1:0] pad_idx_q;
	logic [WIDX_W-1:0]   out_idx_q;

	// schedule memory: message words, then the rolling expanded schedule
	logic [WORD_W-1:0]   sched_mem [SCHED_DEPTH];
	logic [WORD_W-1:0]   rd0_q, rd1_q;
	logic                mem_we;
	logic [SCHED_AW-1:0] mem_wa;
	logic [WORD_W-1:0]   mem_wd;
	logic [SCHED_AW-1:0] rd_a0, rd_a1;

	logic              accept, byte_acc, blk_full, out_take, out_last;
	logic [5:0]        fill;
	logic [WORD_W-1:0] w_new, w_cur, f_val, k_val, t_val;
	logic              pad_first, pad_len_ok;
	logic [SCHED_AW-1:0] pad_wi;
	logic [WORD_W-1:0] pad_80, pad_data;

	assign accept   = msg.valid && msg.ready;
	assign byte_acc = accept && msg.has_byte;
	assign fill     = bit_count_q[8:3];
	assign blk_full = (fill == LAST_FILL);
	assign out_take = digest.valid && digest.ready;
	assign out_last = (out_idx_q == LAST_WIDX);

	// schedule: w[t-3] and w[t-8] from the history line, w[t-14] and w[t-16]
	// from the memory read issued in the previous cycle
	always_comb begin
		w_new = hist_q[2] ^ hist_q[7] ^ rd1_q ^ rd0_q;
		w_new = {w_new[WORD_W-2:0], w_new[WORD_W-1]};
		w_cur = (rnd_q < MSG_ROUNDS) ? rd0_q : w_new;
	end

	// round function and constant by phase
	always_comb begin
		if (rnd_q < PH1_ROUND) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K0;
		end else if (rnd_q < PH2_ROUND) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K1;
		end else if (rnd_q < PH3_ROUND) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K3;
		end
		t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_cur;
	end

	// padding: first word carries the buffered bytes and the 0x80 marker,
	// the length sits in the last two words of the final block
	always_comb begin
		pad_first  = !pad_started_q;
		pad_wi     = pad_first ? bit_count_q[8:5] : pad_idx_q;
		pad_len_ok = pad_first ? (bit_count_q[8:6] != 3'b111) : len_ok_q;
		pad_80     = {acc_q, PAD_BYTE} << {~bit_count_q[4:3], 3'b000};
		if (pad_first) begin
			pad_data = pad_80;
		end else if (pad_len_ok && pad_wi == LEN_HI_WORD) begin
			pad_data = bit_count_q[63:32];
		end else if (pad_len_ok && pad_wi == LEN_LO_WORD) begin
			pad_data = bit_count_q[31:0];
		end else begin
			pad_data = '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (byte_acc && blk_full) begin
					state_d = ST_PREFETCH;
				end else if (accept && msg.end_of_message) begin
					state_d = ST_PAD;
				end
			end
			ST_PREFETCH: begin
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (rnd_q == LAST_ROUND) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (pad_done_q) begin
					state_d = ST_OUT;
				end else if (end_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PAD: begin
				if (pad_wi == LEN_LO_WORD) begin
					state_d = ST_PREFETCH;
				end
			end
			ST_OUT: begin
				if (out_take && out_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: handshakes and memory port controls
	always_comb begin
		msg.ready    = 1'b0;
		digest.valid = 1'b0;
		mem_we       = 1'b0;
		mem_wa       = pad_wi;
		mem_wd       = pad_data;
		rd_a0        = '0;
		unique case (state_q)
			ST_IDLE: begin
				msg.ready = 1'b1;
				mem_we    = byte_acc && (fill[1:0] == 2'b11);
				mem_wa    = fill[5:2];
				mem_wd    = {acc_q, msg.data_byte};
			end
			ST_PREFETCH: begin
				rd_a0 = '0;
			end
			ST_ROUND: begin
				// next round's words; the slot written now is never among them
				rd_a0  = rnd_q[SCHED_AW-1:0] + 4'd1;
				mem_we = (rnd_q >= MSG_ROUNDS);
				mem_wa = rnd_q[SCHED_AW-1:0];
				mem_wd = w_new;
			end
			ST_FOLD: begin
				mem_we = 1'b0;
			end
			ST_PAD: begin
				mem_we = 1'b1;
			end
			ST_OUT: begin
				digest.valid = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
		rd_a1 = rd_a0 + 4'd2;
	end

	assign digest.digest_word = chain_q[out_idx_q];
	assign digest.word_index  = out_idx_q;
	assign digest.last_word   = out_last;

	// schedule memory, one write and two registered reads
	always_ff @(posedge clk) begin
		if (mem_we) begin
			sched_mem[mem_wa] <= mem_wd;
		end
		rd0_q <= sched_mem[rd_a0];
		rd1_q <= sched_mem[rd_a1];
	end

	// control and chain state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rnd_q         <= '0;
			bit_count_q   <= '0;
			end_q         <= 1'b0;
			pad_started_q <= 1'b0;
			pad_done_q    <= 1'b0;
			len_ok_q      <= 1'b0;
			pad_idx_q     <= '0;
			out_idx_q     <= '0;
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				chain_q[i] <= INIT_CHAIN[i];
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						end_q <= msg.end_of_message;
					end
					if (byte_acc) begin
						bit_count_q <= bit_count_q + 64'd8;
					end
				end
				ST_PREFETCH: begin
					rnd_q <= '0;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
				end
				ST_FOLD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
				end
				ST_PAD: begin
					pad_started_q <= 1'b1;
					pad_idx_q     <= pad_wi + 4'd1;
					len_ok_q      <= (pad_wi == LEN_LO_WORD) ? 1'b1 : pad_len_ok;
					if (pad_wi == LEN_LO_WORD && pad_len_ok) begin
						pad_done_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (out_take) begin
						if (out_last) begin
							// back to the initial chain for the next message
							out_idx_q     <= '0;
							bit_count_q   <= '0;
							end_q         <= 1'b0;
							pad_started_q <= 1'b0;
							pad_done_q    <= 1'b0;
							len_ok_q      <= 1'b0;
							for (int i = 0; i < CHAIN_WORDS; i++) begin
								chain_q[i] <= INIT_CHAIN[i];
							end
						end else begin
							out_idx_q <= out_idx_q + 3'd1;
						end
					end
				end
				default: begin
					end_q <= end_q;
				end
			endcase
		end
	end

	// byte assembly, working variables and schedule history
	always_ff @(posedge clk) begin
		if (byte_acc) begin
			acc_q <= {acc_q[15:0], msg.data_byte};
		end
		if (state_q == ST_PREFETCH) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == ST_ROUND) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
			hist_q[0] <= w_cur;
			for (int i = 1; i < HIST_DEPTH; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

	`SHA1MD_ASSERT_NOW(a_round_range, state_q == ST_ROUND, rnd_q <= LAST_ROUND)
	`SHA1MD_ASSERT_NOW(a_digest_after_pad, digest.valid, pad_done_q && !msg.ready)
	`SHA1MD_ASSERT_NOW(a_no_sched_overlap, state_q == ST_ROUND && mem_we, mem_wa != rd_a0 && mem_wa != rd_a1)
	`SHA1MD_ASSERT_NEXT(a_restart_clean, out_take && out_last, bit_count_q == 64'd0 && state_q == ST_IDLE && chain_q[0] == INIT_CHAIN[0])

endmodule

@@ dv/sha1_message_digest_core_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sha1_message_digest_core_test
// byte-serial sha-1 core test: a directed table of short messages (known
// digests typed in where they are standard) followed by random messages,
// many around the pad and block boundaries; each digest word is checked
// against the typed digest or else a software copy of the hash, with
// random stalls and one long back-pressure
module sha1_message_digest_core_test;

	import sha1md_pkg::*;

	// sizes of the run
	localparam int RAND_ITEMS   = 170;   // message-bearing items before the random part stops
	localparam int RAND_MSGS    = 5;     // and at least this many random messages
	localparam int HOLD_CYCLES  = 400;   // one long hold-off on the digest side
	localparam int HOLD_AT_WORD = 35;    // digest words taken before the hold-off starts
	localparam int STALL_LIMIT  = 5000;  // cycles with no transaction before giving up
	localparam int DRAIN_CYCLES = 300;   // quiet time after the last digest word
	localparam int MAX_REPORTS  = 10;

	// digests that every sha-1 implementation must produce
	localparam logic [159:0] DG_EMPTY = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
	localparam logic [159:0] DG_ABC   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [WIDX_W-1:0] idx;
		logic              last;
	} digest_beat_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              has;
		logic              eom;
		logic              typed;  // dg holds the digest to expect
		logic [159:0]      dg;
	} stim_row_t;

	localparam int DIR_ROWS = 17;

	// directed table: idle item, empty message twice, "abc" closed on the byte
	// and by a separate end mark, byte extremes, ignored data, one-byte messages
	stim_row_t dir_tab [DIR_ROWS] = '{
		'{8'h00, 1'b0, 1'b0, 1'b0, 160'h0},      // no byte, no end: nothing happens
		'{8'hff, 1'b0, 1'b1, 1'b1, DG_EMPTY},    // dataless end right after reset
		'{8'h00, 1'b0, 1'b1, 1'b1, DG_EMPTY},    // dataless end right after an end
		'{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
		'{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
		'{8'h63, 1'b1, 1'b1, 1'b1, DG_ABC},      // byte and end together
		'{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
		'{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
		'{8'h63, 1'b1, 1'b0, 1'b0, 160'h0},
		'{8'ha5, 1'b0, 1'b0, 1'b0, 160'h0},      // ignored data in the middle
		'{8'h00, 1'b0, 1'b1, 1'b1, DG_ABC},      // end mark on its own
		'{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
		'{8'hff, 1'b1, 1'b0, 1'b0, 160'h0},
		'{8'hff, 1'b0, 1'b0, 1'b0, 160'h0},
		'{8'hff, 1'b1, 1'b1, 1'b0, 160'h0},
		'{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},      // single zero byte
		'{8'hff, 1'b1, 1'b1, 1'b0, 160'h0}       // single all-ones byte
	};

	logic clk;
	logic arst_n;

	sha1md_in_if  msg_ch ();
	sha1md_out_if dig_ch ();

	sha1_message_digest_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (dig_ch)
	);

	// software copy of the hash state
	logic [WORD_W-1:0] chain_sw [CHAIN_WORDS];
	logic [63:0]       msg_bits;
	logic [BYTE_W-1:0] blk_sw [64];

	digest_beat_t digest_q [$];

	int  mismatches;
	int  items_sent;
	int  words_rcvd;
	int  stall_cnt;
	bit  src_steady;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [WORD_W-1:0] rotl(logic [WORD_W-1:0] v, int unsigned s);
		return (v << s) | (v >> (WORD_W - s));
	endfunction

	// 80-round compression of blk_sw into the chain
	function automatic void sha1_compress();
		logic [WORD_W-1:0] w [SCHED_DEPTH];
		logic [WORD_W-1:0] a, b, c, d, e, f, k, t;
		for (int r = 0; r < 16; r++)
			w[r] = {blk_sw[4*r], blk_sw[4*r+1], blk_sw[4*r+2], blk_sw[4*r+3]};
		a = chain_sw[0]; b = chain_sw[1]; c = chain_sw[2];
		d = chain_sw[3]; e = chain_sw[4];
		for (int r = 0; r < 80; r++) begin
			// rolling schedule: the slot being overwritten is w[t-16]
			if (r >= 16)
				w[r%16] = rotl(w[(r+13)%16] ^ w[(r+8)%16] ^ w[(r+2)%16] ^ w[r%16], 1);
			if (r < 20) begin
				f = (b & c) | (~b & d); k = K0;
			end else if (r < 40) begin
				f = b ^ c ^ d; k = K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d); k = K2;
			end else begin
				f = b ^ c ^ d; k = K3;
			end
			t = rotl(a, 5) + f + e + k + w[r%16];
			e = d; d = c; c = rotl(b, 30); b = a; a = t;
		end
		chain_sw[0] += a; chain_sw[1] += b; chain_sw[2] += c;
		chain_sw[3] += d; chain_sw[4] += e;
	endfunction

	function automatic void sha1_restart();
		for (int i = 0; i < CHAIN_WORDS; i++)
			chain_sw[i] = INIT_CHAIN[i];
		msg_bits = '0;
	endfunction

	// absorb one transaction; returns 1 with the digest when it ends a message
	function automatic bit sha1_absorb(logic [BYTE_W-1:0] data, logic has, logic eom,
			output logic [159:0] dg);
		int fill;
		dg = '0;
		if (has) begin
			fill = int'(msg_bits[8:3]);
			blk_sw[fill] = data;
			msg_bits += 64'd8;
			if (fill == 63)
				sha1_compress();
		end
		if (!eom)
			return 1'b0;
		// pad: 0x80, zeros, then the 64-bit length (wrapping count as is)
		fill = int'(msg_bits[8:3]);
		blk_sw[fill] = PAD_BYTE;
		fill++;
		if (fill > 56) begin
			while (fill < 64) begin
				blk_sw[fill] = '0;
				fill++;
			end
			sha1_compress();
			fill = 0;
		end
		while (fill < 56) begin
			blk_sw[fill] = '0;
			fill++;
		end
		for (int i = 0; i < 8; i++)
			blk_sw[56+i] = msg_bits[8*(7-i) +: 8];
		sha1_compress();
		dg = {chain_sw[0], chain_sw[1], chain_sw[2], chain_sw[3], chain_sw[4]};
		sha1_restart();
		return 1'b1;
	endfunction

	// offer one transaction, wait for it to be taken, then book its digest
	task automatic offer_item(logic [BYTE_W-1:0] data, logic has, logic eom,
			logic typed, logic [159:0] typed_dg);
		logic [159:0] dg;
		digest_beat_t beat;
		// random gaps before the item, none in the steady stretch
		while (!src_steady && $urandom_range(0, 99) < 32) begin
			msg_ch.valid <= 1'b0;
			@(posedge clk);
		end
		msg_ch.valid          <= 1'b1;
		msg_ch.data_byte      <= data;
		msg_ch.has_byte       <= has;
		msg_ch.end_of_message <= eom;
		@(posedge clk);
		while (!msg_ch.ready)
			@(posedge clk);
		if (has || eom)
			items_sent++;
		if (sha1_absorb(data, has, eom, dg)) begin
			if (typed)
				dg = typed_dg;
			for (int i = 0; i < CHAIN_WORDS; i++) begin
				beat.word = dg[159-32*i -: 32];
				beat.idx  = WIDX_W'(i);
				beat.last = (i == CHAIN_WORDS - 1);
				digest_q.push_back(beat);
			end
		end
	endtask

	// stimulus
	initial begin
		int msgs;
		int len;
		int pick;
		bit end_alone;
		arst_n                = 1'b0;
		msg_ch.valid          = 1'b0;
		msg_ch.data_byte      = '0;
		msg_ch.has_byte       = 1'b0;
		msg_ch.end_of_message = 1'b0;
		mismatches            = 0;
		items_sent            = 0;
		src_steady            = 1'b0;
		msgs                  = 0;
		sha1_restart();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIR_ROWS; i++)
			offer_item(dir_tab[i].data, dir_tab[i].has, dir_tab[i].eom,
				dir_tab[i].typed, dir_tab[i].dg);

		// random messages; lengths lean toward the pad boundary (55/56 bytes)
		// and the block boundary (63/64/65 bytes), a few span two or three blocks.
		// the 2^64 length wrap cannot be reached in a run of this size
		items_sent = 0;
		while (items_sent < RAND_ITEMS || msgs < RAND_MSGS) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				len = $urandom_range(0, 12);
			else if (pick < 85)
				len = $urandom_range(54, 65);
			else
				len = $urandom_range(66, 130);
			end_alone  = (len == 0) || ($urandom_range(0, 1) == 1);
			src_steady = (msgs >= 3 && msgs < 5);
			for (int i = 0; i < len; i++) begin
				// occasional empty transaction with junk data
				if ($urandom_range(0, 9) == 0)
					offer_item(8'($urandom), 1'b0, 1'b0, 1'b0, 160'h0);
				offer_item(8'($urandom), 1'b1, (i == len - 1) && !end_alone, 1'b0, 160'h0);
			end
			if (end_alone)
				offer_item(8'($urandom), 1'b0, 1'b1, 1'b0, 160'h0);
			msgs++;
		end
		src_steady = 1'b0;
		msg_ch.valid <= 1'b0;

		// drain: the watchdog covers a digest that never comes
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && digest_q.size() == 0)
			$display("sha1_message_digest_core_test passed");
		else
			$display("sha1_message_digest_core_test failed");
		$finish;
	end

	// digest side: check each transaction, then pick the next ready
	initial begin
		int hold_left;
		bit hold_done;
		digest_beat_t exp_beat;
		dig_ch.ready = 1'b0;
		words_rcvd   = 0;
		hold_left    = 0;
		hold_done    = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && dig_ch.valid && dig_ch.ready) begin
				if (digest_q.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("unexpected digest word %h index %0d last %0b",
							dig_ch.digest_word, dig_ch.word_index, dig_ch.last_word);
					mismatches++;
				end else begin
					exp_beat = digest_q.pop_front();
					if (dig_ch.digest_word !== exp_beat.word
							|| dig_ch.word_index !== exp_beat.idx
							|| dig_ch.last_word !== exp_beat.last) begin
						if (mismatches < MAX_REPORTS)
							$display("digest mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
								exp_beat.word, exp_beat.idx, exp_beat.last,
								dig_ch.digest_word, dig_ch.word_index, dig_ch.last_word);
						mismatches++;
					end
				end
				words_rcvd++;
			end
			if (!arst_n) begin
				dig_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				dig_ch.ready <= 1'b0;
			end else if (!hold_done && words_rcvd >= HOLD_AT_WORD && dig_ch.valid) begin
				// long hold-off while a digest waits: the core stalls the message side
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				dig_ch.ready <= 1'b0;
			end else if (words_rcvd >= 50 && words_rcvd < 80) begin
				dig_ch.ready <= 1'b1;
			end else begin
				dig_ch.ready <= ($urandom_range(0, 99) >= 32);
			end
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		stall_cnt = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready))
					stall_cnt = 0;
				else
					stall_cnt++;
				if (stall_cnt >= STALL_LIMIT) begin
					$display("sha1_message_digest_core_test failed");
					$finish;
				end
			end
		end
	end

endmodule
